// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the quoted token splitter.
// No dependencies; include this header where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: splitter check");

// Check a property on every rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: splitter reset check");

`endif

// ===== design/qts_pkg.sv =====
// Shared types and constants for the quoted token splitter.
// No dependencies; used by qts_regs, qts_step and the top level.
package qts_pkg;

    localparam int NUM_SEP_REGS = 4;
    localparam int SEP_CNT_W    = 3;
    localparam int CHAR_W       = 8;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 5;
    localparam int REG_IDX_W    = 3;

    localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

    // Register indexes (byte address = 4 * index).
    localparam logic [REG_IDX_W-1:0] REG_SEP_0     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEP_1     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEP_2     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEP_3     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEP_COUNT = 3'd4;

    localparam logic [CHAR_W-1:0]    SEP_0_RESET     = 8'd32;
    localparam logic [CHAR_W-1:0]    SEP_N_RESET     = 8'd0;
    localparam logic [SEP_CNT_W-1:0] SEP_COUNT_RESET = 3'd1;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] token_byte;
        logic              byte_valid;
        logic              token_close;
        logic              token_drop;
        logic              string_done;
    } t_out_item;

    typedef struct packed {
        logic [NUM_SEP_REGS-1:0][CHAR_W-1:0] sep_byte;
        logic [SEP_CNT_W-1:0]                sep_count;
    } t_cfg;

    typedef struct packed {
        logic              in_token;
        logic              in_quote;
        logic [CHAR_W-1:0] prev_char;
    } t_state;

endpackage

// ===== design/qts_regs.sv =====
// APB configuration registers of the quoted token splitter: separators and count.
// Depends on qts_pkg.
module qts_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qts_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output qts_pkg::t_cfg                  o_cfg
);

    qts_pkg::t_cfg r_cfg;
    qts_pkg::t_cfg n_cfg;
    logic [qts_pkg::REG_IDX_W-1:0] w_idx;
    logic                          w_wr;

    assign w_idx  = paddr[qts_pkg::APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                qts_pkg::REG_SEP_0:     n_cfg.sep_byte[0] = pwdata[qts_pkg::CHAR_W-1:0];
                qts_pkg::REG_SEP_1:     n_cfg.sep_byte[1] = pwdata[qts_pkg::CHAR_W-1:0];
                qts_pkg::REG_SEP_2:     n_cfg.sep_byte[2] = pwdata[qts_pkg::CHAR_W-1:0];
                qts_pkg::REG_SEP_3:     n_cfg.sep_byte[3] = pwdata[qts_pkg::CHAR_W-1:0];
                qts_pkg::REG_SEP_COUNT: n_cfg.sep_count = pwdata[qts_pkg::SEP_CNT_W-1:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            qts_pkg::REG_SEP_0: begin
                prdata = qts_pkg::APB_DATA_W'(r_cfg.sep_byte[0]);
            end
            qts_pkg::REG_SEP_1: begin
                prdata = qts_pkg::APB_DATA_W'(r_cfg.sep_byte[1]);
            end
            qts_pkg::REG_SEP_2: begin
                prdata = qts_pkg::APB_DATA_W'(r_cfg.sep_byte[2]);
            end
            qts_pkg::REG_SEP_3: begin
                prdata = qts_pkg::APB_DATA_W'(r_cfg.sep_byte[3]);
            end
            qts_pkg::REG_SEP_COUNT: begin
                prdata = qts_pkg::APB_DATA_W'(r_cfg.sep_count);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sep_byte[0] <= qts_pkg::SEP_0_RESET;
            r_cfg.sep_byte[1] <= qts_pkg::SEP_N_RESET;
            r_cfg.sep_byte[2] <= qts_pkg::SEP_N_RESET;
            r_cfg.sep_byte[3] <= qts_pkg::SEP_N_RESET;
            r_cfg.sep_count   <= qts_pkg::SEP_COUNT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/qts_step.sv =====
// Per-character step logic of the quoted token splitter: classifies one character
// against the separators and the quote state. Depends on qts_pkg.
module qts_step (
    input  qts_pkg::t_cfg      i_cfg,
    input  qts_pkg::t_state    i_state,
    input  qts_pkg::t_in_item  i_item,
    output qts_pkg::t_state    o_state,
    output qts_pkg::t_out_item o_item
);

    logic [qts_pkg::NUM_SEP_REGS-1:0] w_hit;
    logic w_sep;
    logic w_uq;
    logic w_emit;
    logic w_tend;
    logic w_drop;
    logic w_last;
    logic [qts_pkg::CHAR_W-1:0] w_c;

    assign w_c    = i_item.char_in;
    assign w_last = i_item.end_of_string;

    // A count at or above the register count enables every separator.
    always_comb begin
        for (int k = 0; k < qts_pkg::NUM_SEP_REGS; k++) begin
            w_hit[k] = (i_cfg.sep_byte[k] == w_c) &&
                       (i_cfg.sep_count > qts_pkg::SEP_CNT_W'(k));
        end
    end

    assign w_sep = |w_hit;
    assign w_uq  = (w_c == qts_pkg::CH_QUOTE) && (i_state.prev_char != qts_pkg::CH_BACKSLASH);

    always_comb begin
        w_emit  = 1'b0;
        w_tend  = 1'b0;
        w_drop  = 1'b0;
        o_state = i_state;
        if (i_state.in_token) begin
            if (!i_state.in_quote) begin
                if (w_sep) begin
                    w_tend           = 1'b1;
                    o_state.in_token = 1'b0;
                end else begin
                    w_emit = 1'b1;
                    w_tend = w_last;
                end
            end else if (w_uq) begin
                w_tend           = 1'b1;
                o_state.in_token = 1'b0;
                o_state.in_quote = 1'b0;
            end else if (w_last) begin
                w_drop = 1'b1;
            end else begin
                w_emit = 1'b1;
            end
        end else if (!w_sep) begin
            if (w_uq) begin
                // Lone opening quote on the last character is dropped.
                w_drop           = w_last;
                o_state.in_token = 1'b1;
                o_state.in_quote = 1'b1;
            end else begin
                w_emit           = 1'b1;
                w_tend           = w_last;
                o_state.in_token = 1'b1;
            end
        end
        o_state.prev_char = w_c;
        if (w_last) begin
            o_state.in_token  = 1'b0;
            o_state.in_quote  = 1'b0;
            o_state.prev_char = qts_pkg::CH_NUL;
        end
    end

    assign o_item.token_byte  = w_emit ? w_c : qts_pkg::CH_NUL;
    assign o_item.byte_valid  = w_emit;
    assign o_item.token_close = w_tend;
    assign o_item.token_drop  = w_drop;
    assign o_item.string_done = w_last;

endmodule

// ===== design/quoted_token_splitter_unit.sv =====
// Quoted token splitter: one character in, one result item out.
// Each accepted item passes the input register, then the output register.
// Throughput: 1 item per cycle while the output is not stalled; the only loop is the tokenizer state.
// Reset (synchronous, active low) empties both stages, closes any open token and
// returns the separators to a single space. Depends on qts_pkg, qts_regs, qts_step.
module quoted_token_splitter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  qts_pkg::t_in_item              i_in_item,
    // Result item channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output qts_pkg::t_out_item             o_out_item,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qts_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

`include "assert_macros.svh"

    qts_pkg::t_cfg      w_cfg;
    qts_pkg::t_state    r_state;
    qts_pkg::t_state    n_state;
    qts_pkg::t_state    w_step_state;
    qts_pkg::t_in_item  r_in_item;
    qts_pkg::t_out_item r_out_item;
    qts_pkg::t_out_item w_step_item;
    logic               r_in_valid;
    logic               n_in_valid;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_out_free;
    logic               w_step_fire;
    logic               w_in_fire;

    qts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The step logic works on the item in the input register against the
    // live tokenizer state; its result lands in the output register.
    qts_step u_step (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_item  (r_in_item),
        .o_state (w_step_state),
        .o_item  (w_step_item)
    );

    // The output register is free when empty or when its item leaves now.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step_fire = r_in_valid && w_out_free;
    // Hold the input side only when a loaded input register cannot advance.
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_fire   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_fire) begin
            n_in_valid = 1'b1;
        end else if (w_step_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_step_fire) begin
            n_out_valid = 1'b1;
        end
    end

    // Advance the tokenizer state only when an item is actually stepped.
    assign n_state = w_step_fire ? w_step_state : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_state.in_token  <= 1'b0;
            r_state.in_quote  <= 1'b0;
            r_state.prev_char <= qts_pkg::CH_NUL;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    // Payload registers: load on transfer, no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_item <= i_in_item;
        end
        if (w_step_fire) begin
            r_out_item <= w_step_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A quote can only be open inside a token.
    `ASSERT_CLKD(a_quote_in_token, i_clk, i_rst_n, r_state.in_quote |-> r_state.in_token)

    // A dropped token never also ends or carries a byte, and only at end of string.
    `ASSERT_CLKD(a_drop_excl, i_clk, i_rst_n, (r_out_valid && r_out_item.token_drop) |-> (r_out_item.string_done && !r_out_item.token_close && !r_out_item.byte_valid))

    // Stepping the last character of a string returns the state to reset.
    `ASSERT_CLKD(a_eos_clears, i_clk, i_rst_n, (w_step_fire && r_in_item.end_of_string) |=> (!r_state.in_token && !r_state.in_quote && (r_state.prev_char == qts_pkg::CH_NUL)))

    // The input side stalls only while the output register is held.
    `ASSERT_ALWAYS(a_stall_cause, i_clk, o_in_stall |-> (r_out_valid && i_out_stall))

endmodule
